[rtl/cesp_pkg.sv]
`default_nettype none

package cesp_pkg;

    localparam int QueueDepth = 4;

    localparam logic [7:0] STX      = 8'h02;
    localparam logic [7:0] QUIRK_LO = 8'ha1;
    localparam logic [7:0] QUIRK_HI = 8'hf9;

    localparam int NumCand  = 7;
    localparam int NameMax  = 11;
    localparam int DupLen   = 9;
    localparam int BigUpper = 5;

    typedef enum logic [2:0] {
        ST_HEADER  = 3'd0,
        ST_DATA    = 3'd1,
        ST_BACK    = 3'd2,
        ST_UNKNOWN = 3'd3,
        ST_QUIRK   = 3'd4
    } status_t;

    localparam logic [2:0] CS_NONE = 3'd0;
    localparam logic [2:0] CS_BIG5 = 3'd5;

    localparam logic [7:0] CAND_NAME [NumCand][NameMax] = '{
        '{"i", "s", "c", "i", "i", "-", "d", "e", "v", 8'h00, 8'h00},
        '{"k", "o", "i", "8", "-", "r", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{"k", "o", "i", "8", "-", "u", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{"v", "i", "s", "c", "i", "i", "1", ".", "1", "-", "1"},
        '{"b", "i", "g", "5", "-", "0", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{"B", "I", "G", "5", "-", "0", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{"g", "b", "k", "-", "0", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00}
    };
    localparam logic [3:0] CAND_LEN [NumCand] = '{4'd9, 4'd6, 4'd6, 4'd11, 4'd6, 4'd6, 4'd5};
    localparam logic [2:0] CAND_CS  [NumCand] = '{3'd1, 3'd2, 3'd3, 3'd4, 3'd5, 3'd5, 3'd6};

    localparam logic [7:0] DUP_HEADER [DupLen] = '{
        8'h80, 8'h89, "B", "I", "G", "5", "-", "0", 8'h02
    };

    typedef struct packed {
        logic       replay;
        status_t    status;
        logic [7:0] data;
        logic [2:0] charset;
        logic [3:0] last_idx;
        logic [3:0] data_cnt;
    } cmd_t;

    function automatic logic [7:0] dup_byte(input logic [3:0] k);
        logic [7:0] r;
        r = 8'h00;
        if (k < 4'(DupLen)) begin
            r = DUP_HEADER[k];
        end
        return r;
    endfunction

endpackage

`default_nettype wire

[rtl/ctext_extended_segment_parser.sv]
`default_nettype none

// Channel   Direction  Ports               Payload
// s_ input  in         tvalid tready tdata tuser    in_byte; func, seg_mode
// m_ result out        tvalid tready tdata tuser tlast  out_byte, charset; status
//
// One transfer in per cycle while the command queue has room; most bytes give
// one result, a broken Big5 header replay gives up to nine, one per cycle while the receiver is ready.
// Matched header bytes give no result until the ninth.
// Synchronous active-low reset returns the parser to idle with an empty queue.
// A full queue stalls the front and m_tready the back; the queue absorbs short output stalls.

module ctext_extended_segment_parser #(
    parameter int QUEUE_DEPTH = cesp_pkg::QueueDepth
) (
    input  wire         aclk,
    input  wire         aresetn,
    input  wire         s_tvalid,
    output logic        s_tready,
    input  wire  [7:0]  s_tdata,   // [7:0] in_byte
    input  wire  [1:0]  s_tuser,   // [0] func, [1] seg_mode
    output logic        m_tvalid,
    input  wire         m_tready,
    output logic [15:0] m_tdata,   // [7:0] out_byte, [10:8] charset, [15:11] zero
    output logic [2:0]  m_tuser,   // [2:0] status
    output logic        m_tlast
);

    logic           full;
    logic           accept;
    logic           push;
    logic           pop;
    logic           head_valid;
    cesp_pkg::cmd_t push_cmd;
    cesp_pkg::cmd_t head_cmd;

    assign s_tready = !full;
    assign accept   = s_tvalid && !full;

    cesp_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .accept   (accept),
        .func     (s_tuser[0]),
        .seg_mode (s_tuser[1]),
        .in_byte  (s_tdata),
        .push     (push),
        .cmd      (push_cmd)
    );

    cesp_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_cmd   (push_cmd),
        .pop        (pop),
        .full       (full),
        .head_valid (head_valid),
        .head_cmd   (head_cmd)
    );

    cesp_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .head_valid (head_valid),
        .head_cmd   (head_cmd),
        .pop        (pop),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .m_tlast    (m_tlast)
    );

endmodule

`default_nettype wire

[rtl/cesp_front.sv]
`default_nettype none

module cesp_front (
    input  wire               aclk,
    input  wire               aresetn,
    input  wire               accept,
    input  wire               func,
    input  wire               seg_mode,
    input  wire  [7:0]        in_byte,
    output logic              push,
    output cesp_pkg::cmd_t    cmd
);

    typedef enum logic [4:0] {
        PH_IDLE  = 5'b00001,
        PH_LEN2  = 5'b00010,
        PH_NAME  = 5'b00100,
        PH_QUIRK = 5'b01000,
        PH_DATA  = 5'b10000
    } phase_t;

    phase_t      phase_reg, phase_next;
    logic [13:0] rem_reg, rem_next;
    logic [3:0]  nlen_reg, nlen_next;
    logic [6:0]  match_reg, match_next;
    logic [2:0]  cs_reg, cs_next;
    logic        flag_reg, flag_next;
    logic        mode_reg, mode_next;
    logic [3:0]  qidx_reg, qidx_next;

    logic [13:0] rem_dec;
    logic [13:0] len2_val;
    logic [13:0] qcount;
    logic [3:0]  qidx_inc;
    logic        hit;
    logic [2:0]  hit_idx;
    logic [6:0]  match_upd;

    always_comb begin
        hit     = 1'b0;
        hit_idx = 3'd0;
        for (int j = 0; j < cesp_pkg::NumCand; j++) begin
            if (!hit && match_reg[j] && (nlen_reg == cesp_pkg::CAND_LEN[j])
                    && ((mode_reg && j >= 4) || (!mode_reg && j < 4))) begin
                hit     = 1'b1;
                hit_idx = 3'(j);
            end
        end
    end

    always_comb begin
        match_upd = match_reg;
        for (int j = 0; j < cesp_pkg::NumCand; j++) begin
            if (nlen_reg >= cesp_pkg::CAND_LEN[j]) begin
                match_upd[j] = 1'b0;
            end else if (cesp_pkg::CAND_NAME[j][nlen_reg] != in_byte) begin
                match_upd[j] = 1'b0;
            end
        end
    end

    assign rem_dec  = rem_reg - 14'd1;
    assign len2_val = {rem_reg[6:0], in_byte[6:0]};
    assign qidx_inc = qidx_reg + 4'd1;
    assign qcount   = {10'd0, qidx_inc};

    always_comb begin
        phase_next = phase_reg;
        rem_next   = rem_reg;
        nlen_next  = nlen_reg;
        match_next = match_reg;
        cs_next    = cs_reg;
        flag_next  = flag_reg;
        mode_next  = mode_reg;
        qidx_next  = qidx_reg;
        push       = 1'b0;
        cmd        = '{replay: 1'b0, status: cesp_pkg::ST_HEADER, data: 8'h00,
                       charset: cesp_pkg::CS_NONE, last_idx: 4'd0, data_cnt: 4'd0};
        if (accept) begin
            push = 1'b1;
            if (!func) begin
                phase_next = PH_LEN2;
                rem_next   = {7'd0, in_byte[6:0]};
                mode_next  = seg_mode;
                nlen_next  = 4'd0;
                match_next = 7'h7f;
                cs_next    = cesp_pkg::CS_NONE;
                flag_next  = 1'b0;
                qidx_next  = 4'd0;
            end else begin
                unique case (phase_reg)
                    PH_LEN2: begin
                        rem_next = len2_val;
                        if (len2_val == 14'd0) begin
                            phase_next = PH_IDLE;
                            cs_next    = cesp_pkg::CS_NONE;
                            flag_next  = 1'b0;
                            qidx_next  = 4'd0;
                        end else begin
                            phase_next = PH_NAME;
                        end
                    end
                    PH_NAME: begin
                        rem_next = rem_dec;
                        if (in_byte == cesp_pkg::STX) begin
                            if (!hit) begin
                                phase_next = PH_IDLE;
                                cs_next    = cesp_pkg::CS_NONE;
                                flag_next  = 1'b0;
                                qidx_next  = 4'd0;
                                cmd.status = cesp_pkg::ST_UNKNOWN;
                            end else begin
                                cs_next     = cesp_pkg::CAND_CS[hit_idx];
                                qidx_next   = 4'd0;
                                phase_next  = (hit_idx == 3'(cesp_pkg::BigUpper)) ?
                                              PH_QUIRK : PH_DATA;
                                cmd.charset = cesp_pkg::CAND_CS[hit_idx];
                            end
                        end else begin
                            match_next = match_upd;
                            if (nlen_reg != 4'hf) begin
                                nlen_next = nlen_reg + 4'd1;
                            end
                            if (rem_dec == 14'd0) begin
                                phase_next = PH_IDLE;
                                cs_next    = cesp_pkg::CS_NONE;
                                flag_next  = 1'b0;
                                qidx_next  = 4'd0;
                            end
                        end
                    end
                    PH_QUIRK: begin
                        if (in_byte == cesp_pkg::dup_byte(qidx_reg)
                                && qidx_reg < 4'(cesp_pkg::DupLen)) begin
                            if (qidx_inc == 4'(cesp_pkg::DupLen)) begin
                                qidx_next   = 4'd0;
                                flag_next   = 1'b1;
                                phase_next  = PH_DATA;
                                cmd.status  = cesp_pkg::ST_QUIRK;
                                cmd.charset = cesp_pkg::CS_BIG5;
                            end else begin
                                qidx_next = qidx_inc;
                                push      = 1'b0;
                            end
                        end else begin
                            cmd.replay   = 1'b1;
                            cmd.data     = in_byte;
                            cmd.last_idx = qidx_reg;
                            qidx_next    = 4'd0;
                            if (rem_reg < qcount) begin
                                cmd.data_cnt = rem_reg[3:0];
                                rem_next     = 14'd0;
                                phase_next   = PH_IDLE;
                                cs_next      = cesp_pkg::CS_NONE;
                                flag_next    = 1'b0;
                            end else begin
                                cmd.data_cnt = qidx_inc;
                                rem_next     = rem_reg - qcount;
                                phase_next   = PH_DATA;
                            end
                        end
                    end
                    PH_DATA: begin
                        cmd.data = in_byte;
                        if (rem_reg == 14'd0) begin
                            if (flag_reg && cs_reg == cesp_pkg::CS_BIG5
                                    && in_byte >= cesp_pkg::QUIRK_LO
                                    && in_byte <= cesp_pkg::QUIRK_HI) begin
                                rem_next    = 14'd1;
                                cmd.status  = cesp_pkg::ST_DATA;
                                cmd.charset = cs_reg;
                            end else begin
                                phase_next = PH_IDLE;
                                cs_next    = cesp_pkg::CS_NONE;
                                flag_next  = 1'b0;
                                qidx_next  = 4'd0;
                                cmd.status = cesp_pkg::ST_BACK;
                            end
                        end else begin
                            rem_next    = rem_dec;
                            cmd.status  = cesp_pkg::ST_DATA;
                            cmd.charset = cs_reg;
                        end
                    end
                    default: begin
                        cmd.status = cesp_pkg::ST_BACK;
                        cmd.data   = in_byte;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_IDLE;
            rem_reg   <= 14'd0;
            nlen_reg  <= 4'd0;
            match_reg <= 7'h7f;
            cs_reg    <= cesp_pkg::CS_NONE;
            flag_reg  <= 1'b0;
            mode_reg  <= 1'b0;
            qidx_reg  <= 4'd0;
        end else begin
            phase_reg <= phase_next;
            rem_reg   <= rem_next;
            nlen_reg  <= nlen_next;
            match_reg <= match_next;
            cs_reg    <= cs_next;
            flag_reg  <= flag_next;
            mode_reg  <= mode_next;
            qidx_reg  <= qidx_next;
        end
    end

endmodule

`default_nettype wire

[rtl/cesp_queue.sv]
`default_nettype none

module cesp_queue #(
    parameter int DEPTH = cesp_pkg::QueueDepth
) (
    input  wire               aclk,
    input  wire               aresetn,
    input  wire               push,
    input  cesp_pkg::cmd_t    push_cmd,
    input  wire               pop,
    output logic              full,
    output logic              head_valid,
    output cesp_pkg::cmd_t    head_cmd
);

    localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CntW = $clog2(DEPTH + 1);

    cesp_pkg::cmd_t entry_reg [DEPTH];
    logic [PtrW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CntW-1:0] count_reg;
    logic            do_push, do_pop;

    assign full       = (count_reg == CntW'(DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_cmd   = entry_reg[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = pop && head_valid;

    always_ff @(posedge aclk) begin
        if (do_push) begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= (wr_ptr_reg == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_reg + PtrW'(1);
            end
            if (do_pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_reg + PtrW'(1);
            end
            if (do_push && !do_pop) begin
                count_reg <= count_reg + CntW'(1);
            end else if (do_pop && !do_push) begin
                count_reg <= count_reg - CntW'(1);
            end
        end
    end

endmodule

`default_nettype wire

[rtl/cesp_back.sv]
`default_nettype none

module cesp_back (
    input  wire               aclk,
    input  wire               aresetn,
    input  wire               head_valid,
    input  cesp_pkg::cmd_t    head_cmd,
    output logic              pop,
    output logic              m_tvalid,
    input  wire               m_tready,
    output logic [15:0]       m_tdata,
    output logic [2:0]        m_tuser,
    output logic              m_tlast
);

    logic [3:0]  idx_reg;
    logic        valid_reg;
    logic [7:0]  byte_reg;
    logic [2:0]  cs_reg;
    logic [2:0]  status_reg;
    logic        last_reg;

    logic        advance;
    logic        is_last;
    logic [7:0]  res_byte;
    logic [2:0]  res_cs;
    logic [2:0]  res_status;

    assign advance = head_valid && (!valid_reg || m_tready);
    assign is_last = (idx_reg == head_cmd.last_idx);
    assign pop     = advance && is_last;

    always_comb begin
        res_byte   = head_cmd.data;
        res_cs     = head_cmd.charset;
        res_status = head_cmd.status;
        if (head_cmd.replay) begin
            if (idx_reg < head_cmd.last_idx) begin
                res_byte = cesp_pkg::dup_byte(idx_reg);
            end
            if (idx_reg < head_cmd.data_cnt) begin
                res_status = cesp_pkg::ST_DATA;
                res_cs     = cesp_pkg::CS_BIG5;
            end else begin
                res_status = cesp_pkg::ST_BACK;
                res_cs     = cesp_pkg::CS_NONE;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            byte_reg   <= res_byte;
            cs_reg     <= res_cs;
            status_reg <= res_status;
            last_reg   <= is_last;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            idx_reg   <= 4'd0;
        end else begin
            if (advance) begin
                valid_reg <= 1'b1;
                idx_reg   <= is_last ? 4'd0 : idx_reg + 4'd1;
            end else if (m_tready) begin
                valid_reg <= 1'b0;
            end
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = {5'd0, cs_reg, byte_reg};
    assign m_tuser  = status_reg;
    assign m_tlast  = last_reg;

endmodule

`default_nettype wire

[bench/ctext_extended_segment_parser_tb.sv]
`timescale 1ns / 1ps

module ctext_extended_segment_parser_tb;
    import cesp_pkg::*;

    localparam logic [2:0] CS_ISCII  = 3'd1;
    localparam logic [2:0] CS_KOI8R  = 3'd2;
    localparam logic [2:0] CS_KOI8U  = 3'd3;
    localparam logic [2:0] CS_VISCII = 3'd4;
    localparam logic [2:0] CS_GBK    = 3'd6;

    localparam int NAME_COUNT     = 7;
    localparam int IDX_WIDE_FIRST = 4;
    localparam int IDX_BIG5_UPPER = 5;
    localparam int DUP_COUNT      = 9;
    localparam int NAME_LEN_SAT   = 15;
    localparam int RANDOM_ITEMS   = 40;
    localparam int TAIL_ITEMS     = 25;

    typedef enum logic [2:0] {
        P_IDLE,
        P_LEN2,
        P_NAME,
        P_QUIRK,
        P_DATA
    } seg_phase_t;

    typedef struct packed {
        status_t    status;
        logic [7:0] out_byte;
        logic [2:0] charset;
        logic       last;
    } seg_result_t;

    typedef struct packed {
        logic       func;
        logic       mode;
        logic [7:0] data;
    } in_item_t;

    typedef logic [7:0] bytes_t[$];

    class segment_tracker;
        seg_phase_t  phase;
        logic [13:0] remaining;
        logic [3:0]  name_len;
        logic [6:0]  match_bits;
        logic [2:0]  charset;
        logic        quirk_flag;
        logic        wide_mode;
        logic [7:0]  held [DUP_COUNT];
        int          held_cnt;
        seg_result_t pending_results[$];
        seg_result_t step_out[$];
        int          errors;
        int          checked;
        int          quirk_skips;
        int          unknown_names;
        int          bytes_in;

        function new();
            phase         = P_IDLE;
            remaining     = '0;
            name_len      = '0;
            match_bits    = '1;
            charset       = CS_NONE;
            quirk_flag    = 1'b0;
            wide_mode     = 1'b0;
            held_cnt      = 0;
            errors        = 0;
            checked       = 0;
            quirk_skips   = 0;
            unknown_names = 0;
            bytes_in      = 0;
        endfunction

        static function string known_name(int j);
            case (j)
                0: return "iscii-dev";
                1: return "koi8-r";
                2: return "koi8-u";
                3: return "viscii1.1-1";
                4: return "big5-0";
                5: return "BIG5-0";
                6: return "gbk-0";
                default: return "";
            endcase
        endfunction

        static function logic [2:0] known_charset(int j);
            case (j)
                0: return CS_ISCII;
                1: return CS_KOI8R;
                2: return CS_KOI8U;
                3: return CS_VISCII;
                4: return CS_BIG5;
                5: return CS_BIG5;
                6: return CS_GBK;
                default: return CS_NONE;
            endcase
        endfunction

        static function logic [7:0] dup_header_byte(int k);
            case (k)
                0: return 8'h80;
                1: return 8'h89;
                2: return 8'h42;
                3: return 8'h49;
                4: return 8'h47;
                5: return 8'h35;
                6: return 8'h2d;
                7: return 8'h30;
                default: return STX;
            endcase
        endfunction

        function void emit(status_t st, logic [7:0] b, logic [2:0] cs);
            seg_result_t r;
            r.status   = st;
            r.out_byte = b;
            r.charset  = cs;
            r.last     = 1'b0;
            step_out.push_back(r);
        endfunction

        function void end_segment();
            phase      = P_IDLE;
            charset    = CS_NONE;
            quirk_flag = 1'b0;
            held_cnt   = 0;
        endfunction

        function void pass_data(logic [7:0] b);
            if (phase != P_DATA) begin
                emit(ST_BACK, b, CS_NONE);
                return;
            end
            if (remaining == 0) begin
                if (quirk_flag && charset == CS_BIG5 && b >= QUIRK_LO && b <= QUIRK_HI) begin
                    remaining = 14'd2;
                end else begin
                    end_segment();
                    emit(ST_BACK, b, CS_NONE);
                    return;
                end
            end
            remaining = remaining - 14'd1;
            emit(ST_DATA, b, charset);
        endfunction

        function void match_name(logic [7:0] b);
            int    j;
            string s;
            for (j = 0; j < NAME_COUNT; j++) begin
                s = known_name(j);
                if (match_bits[j] && (name_len >= s.len() || s[name_len] != b)) begin
                    match_bits[j] = 1'b0;
                end
            end
            if (name_len != NAME_LEN_SAT) begin
                name_len = name_len + 4'd1;
            end
        endfunction

        function void parse_byte(logic func, logic mode, logic [7:0] b);
            int    j;
            int    k;
            int    hit;
            string s;
            step_out.delete();
            bytes_in++;
            if (!func) begin
                end_segment();
                phase      = P_LEN2;
                remaining  = {7'd0, b[6:0]};
                wide_mode  = mode;
                name_len   = '0;
                match_bits = '1;
                emit(ST_HEADER, 8'h00, CS_NONE);
            end else if (phase == P_LEN2) begin
                remaining = {remaining[6:0], b[6:0]};
                if (remaining == 0) begin
                    end_segment();
                end else begin
                    phase = P_NAME;
                end
                emit(ST_HEADER, 8'h00, CS_NONE);
            end else if (phase == P_NAME) begin
                remaining = remaining - 14'd1;
                if (b == STX) begin
                    hit = -1;
                    for (j = (wide_mode ? IDX_WIDE_FIRST : 0);
                         j < (wide_mode ? NAME_COUNT : IDX_WIDE_FIRST); j++) begin
                        s = known_name(j);
                        if (hit < 0 && match_bits[j] && name_len == s.len()) begin
                            hit = j;
                        end
                    end
                    if (hit < 0) begin
                        end_segment();
                        emit(ST_UNKNOWN, 8'h00, CS_NONE);
                    end else begin
                        charset  = known_charset(hit);
                        held_cnt = 0;
                        phase    = (hit == IDX_BIG5_UPPER) ? P_QUIRK : P_DATA;
                        emit(ST_HEADER, 8'h00, charset);
                    end
                end else begin
                    match_name(b);
                    if (remaining == 0) begin
                        end_segment();
                    end
                    emit(ST_HEADER, 8'h00, CS_NONE);
                end
            end else if (phase == P_QUIRK) begin
                if (b == dup_header_byte(held_cnt)) begin
                    held[held_cnt] = b;
                    held_cnt++;
                    if (held_cnt == DUP_COUNT) begin
                        held_cnt   = 0;
                        quirk_flag = 1'b1;
                        phase      = P_DATA;
                        emit(ST_QUIRK, 8'h00, CS_BIG5);
                    end
                end else begin
                    k        = held_cnt;
                    phase    = P_DATA;
                    held_cnt = 0;
                    for (j = 0; j < k; j++) begin
                        pass_data(held[j]);
                    end
                    pass_data(b);
                end
            end else begin
                pass_data(b);
            end
            if (step_out.size() > 0) begin
                step_out[step_out.size() - 1].last = 1'b1;
            end
            for (j = 0; j < step_out.size(); j++) begin
                pending_results.push_back(step_out[j]);
            end
        endfunction

        function void check_result(seg_result_t got);
            seg_result_t want;
            if (pending_results.size() == 0) begin
                errors++;
                $display("%0t: unexpected result: status %0d byte %h charset %0d last %0b",
                         $time, got.status, got.out_byte, got.charset, got.last);
                return;
            end
            want = pending_results.pop_front();
            checked++;
            if (got.status !== want.status || got.out_byte !== want.out_byte ||
                got.charset !== want.charset || got.last !== want.last) begin
                errors++;
                $display("%0t: mismatch: expected status %0d byte %h charset %0d last %0b",
                         $time, want.status, want.out_byte, want.charset, want.last);
                $display("%0t:          actual   status %0d byte %h charset %0d last %0b",
                         $time, got.status, got.out_byte, got.charset, got.last);
            end
            if (want.status == ST_QUIRK) begin
                quirk_skips++;
            end
            if (want.status == ST_UNKNOWN) begin
                unknown_names++;
            end
        endfunction
    endclass

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata  = 8'h00;
    logic [1:0]  s_tuser  = 2'b00;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;
    logic [2:0]  m_tuser;
    logic        m_tlast;

    segment_tracker tracker;
    in_item_t       feed_q[$];
    int             n_segments = 0;
    bit             quiet_tail = 1'b0;

    ctext_extended_segment_parser DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    initial begin
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
    end

    initial begin
        #5_000_000;
        $display("ctext_extended_segment_parser regression: fail");
        $finish;
    end

    function automatic void push_byte(logic func, logic mode, logic [7:0] b);
        in_item_t it;
        it.func = func;
        it.mode = mode;
        it.data = b;
        feed_q.push_back(it);
        if (!func) begin
            n_segments++;
        end
    endfunction

    function automatic bytes_t to_bytes(string s);
        bytes_t q;
        int     i;
        for (i = 0; i < s.len(); i++) begin
            q.push_back(s[i]);
        end
        return q;
    endfunction

    // length, name, optional STX, repeated-header prefix, data, then bytes past the count
    function automatic void push_segment(logic mode, bytes_t name, logic stx, int count,
                                         int hdr_len, int ndata, int tail);
        logic [13:0] c;
        int          i;
        c = count[13:0];
        push_byte(1'b0, mode, {1'($urandom_range(0, 1)), c[13:7]});
        push_byte(1'b1, 1'($urandom_range(0, 1)), {1'($urandom_range(0, 1)), c[6:0]});
        for (i = 0; i < name.size(); i++) begin
            push_byte(1'b1, 1'($urandom_range(0, 1)), name[i]);
        end
        if (stx) begin
            push_byte(1'b1, 1'($urandom_range(0, 1)), STX);
        end
        for (i = 0; i < hdr_len; i++) begin
            push_byte(1'b1, 1'($urandom_range(0, 1)), segment_tracker::dup_header_byte(i));
        end
        for (i = 0; i < ndata; i++) begin
            push_byte(1'b1, 1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
        end
        for (i = 0; i < tail; i++) begin
            push_byte(1'b1, 1'($urandom_range(0, 1)),
                      $urandom_range(0, 1) ? 8'($urandom_range(QUIRK_LO, QUIRK_HI))
                                           : 8'($urandom_range(0, 255)));
        end
    endfunction

    function automatic void build_directed();
        bytes_t q;
        push_byte(1'b1, 1'b1, 8'h00);
        push_byte(1'b1, 1'b0, 8'hff);
        push_segment(1'b0, q, 1'b0, 0, 0, 0, 1);
        // longest count, broken repeated header, then restart mid-segment
        push_segment(1'b1, to_bytes("BIG5-0"), 1'b1, 16383, 3, 1, 0);
        push_segment(1'b0, to_bytes("koi8-u"), 1'b1, 9, 0, 2, 1);
        push_segment(1'b0, to_bytes("koi8-r"), 1'b0, 3, 0, 0, 2);
        push_segment(1'b1, to_bytes("much-too-long-name"), 1'b1, 19, 0, 0, 0);
        push_segment(1'b1, to_bytes("BIG5-0"), 1'b1, 9, DUP_COUNT, 2, 0);
        push_byte(1'b1, 1'b0, QUIRK_LO);
        push_byte(1'b1, 1'b1, QUIRK_HI);
        push_byte(1'b1, 1'b0, 8'h41);
    endfunction

    function automatic void build_random();
        bytes_t name;
        int     base;
        int     kind;
        int     j;
        int     n;
        int     hdr;
        int     ndata;
        int     count;
        logic   mode;
        base = feed_q.size();
        while (feed_q.size() - base < RANDOM_ITEMS) begin
            kind = $urandom_range(0, 9);
            if (kind == 0) begin
                push_byte(1'($urandom_range(0, 4) != 0), 1'($urandom_range(0, 1)),
                          8'($urandom_range(0, 255)));
            end else if (kind <= 7) begin
                j     = $urandom_range(0, NAME_COUNT - 1);
                name  = to_bytes(segment_tracker::known_name(j));
                mode  = (j >= IDX_WIDE_FIRST);
                if ($urandom_range(0, 7) == 0) begin
                    mode = !mode;
                end
                ndata = $urandom_range(0, 6);
                hdr   = 0;
                if (j == IDX_BIG5_UPPER) begin
                    case ($urandom_range(0, 2))
                        0:       hdr = 0;
                        1:       hdr = DUP_COUNT;
                        default: hdr = $urandom_range(1, DUP_COUNT - 1);
                    endcase
                end
                count = name.size() + 1 + ndata;
                if ($urandom_range(0, 5) == 0) begin
                    count = $urandom_range(0, name.size());
                end
                push_segment(mode, name, 1'b1, count, hdr, ndata, $urandom_range(0, 3));
            end else if (kind == 8) begin
                name.delete();
                n = $urandom_range(1, 17);
                for (j = 0; j < n; j++) begin
                    name.push_back(8'($urandom_range(8'h61, 8'h7a)));
                end
                push_segment(1'($urandom_range(0, 1)), name, 1'b1, n + 3, 0, 2, 1);
            end else begin
                name = to_bytes(segment_tracker::known_name($urandom_range(0, NAME_COUNT - 1)));
                n    = $urandom_range(0, name.size());
                while (name.size() > n) begin
                    void'(name.pop_back());
                end
                push_segment(1'($urandom_range(0, 1)), name, 1'($urandom_range(0, 1)),
                             $urandom_range(0, 40), 0, 0, 0);
            end
        end
    endfunction

    task automatic drive_input();
        int i;
        int gap;
        for (i = 0; i < feed_q.size(); i++) begin
            quiet_tail = (i >= feed_q.size() - TAIL_ITEMS);
            gap = (!quiet_tail && $urandom_range(0, 3) == 0) ? $urandom_range(1, 12) : 0;
            if (gap > 0) begin
                @(negedge aclk);
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            @(negedge aclk);
            s_tvalid <= 1'b1;
            s_tdata  <= feed_q[i].data;
            s_tuser  <= {feed_q[i].mode, feed_q[i].func};
            @(posedge aclk);
            while (!s_tready) @(posedge aclk);
        end
        @(negedge aclk);
        s_tvalid <= 1'b0;
    endtask

    // receiver: random stalls, one long hold-off to back up the input
    initial begin
        int hold;
        bit long_done;
        hold      = 0;
        long_done = 1'b0;
        forever begin
            @(negedge aclk);
            if (!long_done && tracker != null && tracker.checked >= 40) begin
                long_done = 1'b1;
                hold      = 100;
            end else if (hold == 0 && !quiet_tail && $urandom_range(0, 5) == 0) begin
                hold = $urandom_range(1, 12);
            end
            if (hold > 0) begin
                hold--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    always @(posedge aclk) begin : watch
        seg_result_t seen;
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                tracker.parse_byte(s_tuser[0], s_tuser[1], s_tdata);
            end
            if (m_tvalid && m_tready) begin
                seen.status   = status_t'(m_tuser);
                seen.out_byte = m_tdata[7:0];
                seen.charset  = m_tdata[10:8];
                seen.last     = m_tlast;
                tracker.check_result(seen);
            end
        end
    end

    initial begin
        tracker = new();
        build_directed();
        build_random();
        @(negedge aclk);
        while (!aresetn) @(negedge aclk);
        drive_input();
        while (tracker.pending_results.size() != 0) @(posedge aclk);
        repeat (32) @(posedge aclk);
        $display("covered %0d input bytes in %0d segments, %0d results checked",
                 tracker.bytes_in, n_segments, tracker.checked);
        $display("including %0d Big5 header skips and %0d unknown charset names",
                 tracker.quirk_skips, tracker.unknown_names);
        if (tracker.errors == 0) begin
            $display("ctext_extended_segment_parser regression: pass");
        end else begin
            $display("ctext_extended_segment_parser regression: fail");
        end
        $finish;
    end

endmodule
